@@ rtl/cpep_pkg.sv @@
// Shared types, constants and helper functions for the car pose propagator.
// Depends on nothing; used by car_pose_euler_propagator.
`default_nettype none

package cpep_pkg;

    localparam int unsigned CordicIters = 30;
    localparam int unsigned DivIters    = 64;

    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [29:0]        InvTwoPi   = 30'd683565276;

    localparam logic [2:0] REG_WHEELBASE = 3'd0;
    localparam logic [2:0] REG_TIME_STEP = 3'd1;
    localparam logic [2:0] REG_X_MIN     = 3'd2;
    localparam logic [2:0] REG_X_MAX     = 3'd3;
    localparam logic [2:0] REG_Y_MIN     = 3'd4;
    localparam logic [2:0] REG_Y_MAX     = 3'd5;

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_SCORD = 17'b00000000000000010,
        S_TLOAD = 17'b00000000000000100,
        S_TDIV  = 17'b00000000000001000,
        S_YMUL  = 17'b00000000000010000,
        S_YLOAD = 17'b00000000000100000,
        S_YDIV  = 17'b00000000001000000,
        S_PLAN  = 17'b00000000010000000,
        S_HCORD = 17'b00000000100000000,
        S_MVX   = 17'b00000001000000000,
        S_MVY   = 17'b00000010000000000,
        S_MDX   = 17'b00000100000000000,
        S_MDY   = 17'b00001000000000000,
        S_MRAD  = 17'b00010000000000000,
        S_MQH   = 17'b00100000000000000,
        S_MQL   = 17'b01000000000000000,
        S_DONE  = 17'b10000000000000000
    } t_state;

    typedef struct packed {
        logic              flip;
        logic signed [33:0] z;
    } t_prep;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Brings a binary angle into the right half-plane by a half turn.
    function automatic t_prep prep_angle(input logic [31:0] ang);
        t_prep p;
        logic signed [33:0] a;
        a = {{2{ang[31]}}, ang};
        p.flip = 1'b0;
        if (a > 34'sd1073741824) begin
            a = a - 34'sd2147483648;
            p.flip = 1'b1;
        end else if (a < -34'sd1073741824) begin
            a = a + 34'sd2147483648;
            p.flip = 1'b1;
        end
        p.z = a;
        return p;
    endfunction

    function automatic logic [31:0] sat_quot(input logic [63:0] q, input logic neg);
        logic [31:0] r;
        if (!neg) begin
            r = (q > 64'd2147483647) ? 32'h7FFFFFFF : q[31:0];
        end else begin
            r = (q > 64'd2147483648) ? 32'h80000000 : (32'd0 - q[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/car_pose_euler_propagator.sv @@
// Car pose propagator: kinematic bicycle model with forward Euler steps.
// Depends on cpep_pkg for state codes, register indexes and the CORDIC table.
//
// One request is taken at a time. The steering tangent and yaw rate need a CORDIC
// rotation plus two passes of a bit-serial divider; each Euler step then needs a
// CORDIC rotation for the heading, the states S_MVX to S_MQL on the single shared
// multiplier and the planning state S_PLAN. The result is held in an output
// register, so the next request may enter while it waits to be taken.
`default_nettype none

module car_pose_euler_propagator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_start_x,
    input  wire logic [31:0] i_start_y,
    input  wire logic [31:0] i_start_heading,
    input  wire logic [31:0] i_speed,
    input  wire logic [30:0] i_steer_angle,
    input  wire logic [22:0] i_duration,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_end_x,
    output logic [31:0]      o_end_y,
    output logic [31:0]      o_end_heading
);

    cpep_pkg::t_state r_state, n_state;

    logic [30:0]        r_wheelbase;
    logic [15:0]        r_time_step;
    logic signed [31:0] r_x_min, r_x_max, r_y_min, r_y_max;

    logic signed [31:0] r_x, r_y, r_v, r_tn, r_yaw;
    logic [31:0]        r_h, r_q;
    logic [22:0]        r_left;
    logic [15:0]        r_dt, r_sdt;
    logic [6:0]         r_cnt;
    logic               r_flip;
    logic signed [33:0] r_cx, r_cy, r_cz, r_vx, r_vy;
    logic signed [63:0] r_prod;
    logic [63:0]        r_dq;
    logic [31:0]        r_rem;
    logic [30:0]        r_dvs;
    logic               r_dneg, r_rneg;
    logic [47:0]        r_mag;
    logic               r_out_valid;
    logic [31:0]        r_ox, r_oy, r_oh;

    logic               accept, out_load, cord_last;
    logic signed [33:0] sh_x, sh_y, at, nx, ny, nz;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [32:0]        shifted, diff;
    logic               ge;
    logic signed [34:0] dpos;
    logic signed [35:0] psum;
    logic signed [35:0] lo_b, hi_b;
    logic signed [35:0] clamped;
    logic [31:0]        qsum;
    cpep_pkg::t_prep    prep;

    assign accept   = (r_state == cpep_pkg::S_IDLE) && i_in_valid;
    assign out_load = (r_state == cpep_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign cord_last = (r_cnt[4:0] == 5'(cpep_pkg::CordicIters - 1));

    assign o_in_stall    = (r_state != cpep_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_end_x       = r_ox;
    assign o_end_y       = r_oy;
    assign o_end_heading = r_oh;

    always_comb begin
        sh_x = r_cx >>> r_cnt[4:0];
        sh_y = r_cy >>> r_cnt[4:0];
        at   = {2'b00, cpep_pkg::atan_entry(r_cnt[4:0])};
        if (!r_cz[33]) begin
            nx = r_cx - sh_y;
            ny = r_cy + sh_x;
            nz = r_cz - at;
        end else begin
            nx = r_cx + sh_y;
            ny = r_cy - sh_x;
            nz = r_cz + at;
        end
    end

    always_comb begin
        shifted = {r_rem, r_dq[63]};
        diff    = shifted - {2'b00, r_dvs};
        ge      = !diff[32];
    end

    always_comb begin
        mul_a = {{2{r_v[31]}}, r_v};
        mul_b = r_cx;
        case (r_state)
            cpep_pkg::S_MVY:  mul_b = r_cy;
            cpep_pkg::S_YMUL: mul_b = {{2{r_tn[31]}}, r_tn};
            cpep_pkg::S_MDX: begin
                mul_a = r_vx;
                mul_b = {18'd0, r_sdt};
            end
            cpep_pkg::S_MDY: begin
                mul_a = r_vy;
                mul_b = {18'd0, r_sdt};
            end
            cpep_pkg::S_MRAD: begin
                mul_a = {{2{r_yaw[31]}}, r_yaw};
                mul_b = {18'd0, r_sdt};
            end
            cpep_pkg::S_MQH: begin
                mul_a = {18'd0, r_mag[47:32]};
                mul_b = {4'd0, cpep_pkg::InvTwoPi};
            end
            cpep_pkg::S_MQL: begin
                mul_a = {2'b00, r_mag[31:0]};
                mul_b = {4'd0, cpep_pkg::InvTwoPi};
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        dpos = mul_p[50:16];
        if (r_state == cpep_pkg::S_MDY) begin
            psum = {{4{r_y[31]}}, r_y} + {dpos[34], dpos};
            lo_b = {{4{r_y_min[31]}}, r_y_min};
            hi_b = {{4{r_y_max[31]}}, r_y_max};
        end else begin
            psum = {{4{r_x[31]}}, r_x} + {dpos[34], dpos};
            lo_b = {{4{r_x_min[31]}}, r_x_min};
            hi_b = {{4{r_x_max[31]}}, r_x_max};
        end
        if (psum > hi_b) begin
            clamped = hi_b;
        end else if (psum < lo_b) begin
            clamped = lo_b;
        end else begin
            clamped = psum;
        end
        qsum = r_q + mul_p[63:32];
        prep = cpep_pkg::prep_angle((r_state == cpep_pkg::S_PLAN) ? r_h
                                    : {i_steer_angle[30], i_steer_angle});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpep_pkg::S_IDLE:  if (accept) n_state = cpep_pkg::S_SCORD;
            cpep_pkg::S_SCORD: if (cord_last) n_state = cpep_pkg::S_TLOAD;
            cpep_pkg::S_TLOAD: n_state = cpep_pkg::S_TDIV;
            cpep_pkg::S_TDIV:  if (r_cnt == 7'(cpep_pkg::DivIters)) n_state = cpep_pkg::S_YMUL;
            cpep_pkg::S_YMUL:  n_state = cpep_pkg::S_YLOAD;
            cpep_pkg::S_YLOAD: n_state = cpep_pkg::S_YDIV;
            cpep_pkg::S_YDIV:  if (r_cnt == 7'(cpep_pkg::DivIters)) n_state = cpep_pkg::S_PLAN;
            cpep_pkg::S_PLAN:  n_state = (r_left == 23'd0) ? cpep_pkg::S_DONE
                                                           : cpep_pkg::S_HCORD;
            cpep_pkg::S_HCORD: if (cord_last) n_state = cpep_pkg::S_MVX;
            cpep_pkg::S_MVX:   n_state = cpep_pkg::S_MVY;
            cpep_pkg::S_MVY:   n_state = cpep_pkg::S_MDX;
            cpep_pkg::S_MDX:   n_state = cpep_pkg::S_MDY;
            cpep_pkg::S_MDY:   n_state = cpep_pkg::S_MRAD;
            cpep_pkg::S_MRAD:  n_state = cpep_pkg::S_MQH;
            cpep_pkg::S_MQH:   n_state = cpep_pkg::S_MQL;
            cpep_pkg::S_MQL:   n_state = cpep_pkg::S_PLAN;
            cpep_pkg::S_DONE:  if (out_load) n_state = cpep_pkg::S_IDLE;
            default:           n_state = cpep_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpep_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_wheelbase <= 31'd13107;
            r_time_step <= 16'd655;
            r_x_min     <= 32'sh80000000;
            r_x_max     <= 32'sh7FFFFFFF;
            r_y_min     <= 32'sh80000000;
            r_y_max     <= 32'sh7FFFFFFF;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cpep_pkg::REG_WHEELBASE: r_wheelbase <= i_cfg_data[30:0];
                    cpep_pkg::REG_TIME_STEP: r_time_step <= i_cfg_data[15:0];
                    cpep_pkg::REG_X_MIN:     r_x_min     <= i_cfg_data;
                    cpep_pkg::REG_X_MAX:     r_x_max     <= i_cfg_data;
                    cpep_pkg::REG_Y_MIN:     r_y_min     <= i_cfg_data;
                    cpep_pkg::REG_Y_MAX:     r_y_max     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cpep_pkg::S_IDLE: begin
                r_x     <= i_start_x;
                r_y     <= i_start_y;
                r_h     <= i_start_heading;
                r_v     <= i_speed;
                r_left  <= i_duration;
                r_dt    <= (r_time_step == 16'd0) ? 16'd1 : r_time_step;
                r_cnt   <= 7'd0;
                r_cx    <= cpep_pkg::CordicGain;
                r_cy    <= 34'sd0;
                r_cz    <= prep.z;
                r_flip  <= prep.flip;
            end
            cpep_pkg::S_SCORD, cpep_pkg::S_HCORD: begin
                r_cnt <= r_cnt + 7'd1;
                r_cz  <= nz;
                if (cord_last && r_flip) begin
                    r_cx <= -nx;
                    r_cy <= -ny;
                end else begin
                    r_cx <= nx;
                    r_cy <= ny;
                end
            end
            cpep_pkg::S_TLOAD: begin
                r_cnt  <= 7'd0;
                r_rem  <= 32'd0;
                r_dvs  <= (r_cx < 34'sd1) ? 31'd1 : r_cx[30:0];
                r_dneg <= r_cy[33];
                r_dq   <= {16'd0, (r_cy[33] ? 32'(-r_cy) : r_cy[31:0]), 16'd0};
            end
            cpep_pkg::S_TDIV, cpep_pkg::S_YDIV: begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(cpep_pkg::DivIters)) begin
                    if (r_state == cpep_pkg::S_TDIV) begin
                        r_tn <= cpep_pkg::sat_quot(r_dq, r_dneg);
                    end else begin
                        r_yaw <= cpep_pkg::sat_quot(r_dq, r_dneg);
                    end
                end else begin
                    r_dq  <= {r_dq[62:0], ge};
                    r_rem <= ge ? diff[31:0] : shifted[31:0];
                end
            end
            cpep_pkg::S_YMUL: r_prod <= mul_p[63:0];
            cpep_pkg::S_YLOAD: begin
                r_cnt  <= 7'd0;
                r_rem  <= 32'd0;
                r_dvs  <= (r_wheelbase == 31'd0) ? 31'd1 : r_wheelbase;
                r_dneg <= r_prod[63];
                r_dq   <= r_prod[63] ? 64'(-r_prod) : r_prod;
            end
            cpep_pkg::S_PLAN: begin
                r_cnt  <= 7'd0;
                r_cx   <= cpep_pkg::CordicGain;
                r_cy   <= 34'sd0;
                r_cz   <= prep.z;
                r_flip <= prep.flip;
                if (r_left >= {7'd0, r_dt}) begin
                    r_sdt  <= r_dt;
                    r_left <= r_left - {7'd0, r_dt};
                end else begin
                    r_sdt  <= r_left[15:0];
                    r_left <= 23'd0;
                end
            end
            cpep_pkg::S_MVX:  r_vx <= mul_p[63:30];
            cpep_pkg::S_MVY:  r_vy <= mul_p[63:30];
            cpep_pkg::S_MDX:  r_x  <= clamped[31:0];
            cpep_pkg::S_MDY:  r_y  <= clamped[31:0];
            cpep_pkg::S_MRAD: begin
                r_rneg <= mul_p[67];
                r_mag  <= mul_p[67] ? 48'(-mul_p) : mul_p[47:0];
            end
            cpep_pkg::S_MQH:  r_q <= mul_p[31:0];
            cpep_pkg::S_MQL:  r_h <= r_h + (r_rneg ? (32'd0 - qsum) : qsum);
            cpep_pkg::S_DONE: begin
                if (out_load) begin
                    r_ox <= r_x;
                    r_oy <= r_y;
                    r_oh <= r_h;
                end
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == cpep_pkg::S_SCORD))
        else $error("An accepted request did not start the steering rotation.");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpep_pkg::S_SCORD || r_state == cpep_pkg::S_HCORD)
        |-> (r_cnt < 7'(cpep_pkg::CordicIters)))
        else $error("The rotation counter ran past its last iteration.");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpep_pkg::S_TDIV || r_state == cpep_pkg::S_YDIV)
        |-> (r_cnt <= 7'(cpep_pkg::DivIters)))
        else $error("The divider counter ran past its last iteration.");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpep_pkg::S_DONE && (!o_out_valid || !i_out_stall))
        |=> (o_out_valid && r_state == cpep_pkg::S_IDLE))
        else $error("A finished pose was not presented on the output.");

endmodule

`default_nettype wire

@@ tb/car_pose_euler_propagator_tb.sv @@
// Testbench for car_pose_euler_propagator: drives pose requests, predicts each final pose
// with an integer Euler model of its own and compares every result field by field.
// Depends on cpep_pkg for the register indexes and on the block itself.
`timescale 1ns / 1ps

module car_pose_euler_propagator_tb;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
    } t_pose;

    localparam int unsigned HoldCycles  = 2500;
    localparam int unsigned WatchLimit  = 60000;
    localparam int unsigned SettleGap   = 40;
    localparam longint unsigned OneTurnInv = 64'd683565276;

    localparam logic [31:0] ArcTable [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_start_x;
    logic [31:0] i_start_y;
    logic [31:0] i_start_heading;
    logic [31:0] i_speed;
    logic [30:0] i_steer_angle;
    logic [22:0] i_duration;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_end_x;
    logic [31:0] o_end_y;
    logic [31:0] o_end_heading;

    t_pose  pose_q[$];
    int     mismatches;
    int     idle_cycles;
    bit     calm;
    bit     hold_req;
    int     hold_cnt;

    longint wb_reg;
    longint dt_reg;
    longint x_lo;
    longint x_hi;
    longint y_lo;
    longint y_hi;

    car_pose_euler_propagator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_heading(i_start_heading),
        .i_speed        (i_speed),
        .i_steer_angle  (i_steer_angle),
        .i_duration     (i_duration),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_end_heading  (o_end_heading)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_q16(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint bound(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void rotate_q30(input logic [31:0] ang, output longint c,
                                       output longint s);
        longint a;
        longint x;
        longint y;
        longint nx;
        longint ny;
        bit     flip;
        a = longint'(signed'(ang));
        flip = 1'b0;
        if (a > 64'sd1073741824 || a < -64'sd1073741824) begin
            a = (a > 0) ? a - 64'sd2147483648 : a + 64'sd2147483648;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                a  = a - longint'(ArcTable[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                a  = a + longint'(ArcTable[i]);
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void euler_move(inout longint x, inout longint y,
                                       inout logic [31:0] h, input longint v,
                                       input longint yaw, input longint dt);
        longint c;
        longint s;
        longint vx;
        longint vy;
        longint rad;
        longint unsigned mag;
        longint unsigned q;
        rotate_q30(h, c, s);
        vx = (v * c) >>> 30;
        vy = (v * s) >>> 30;
        x = bound(x + ((vx * dt) >>> 16), x_lo, x_hi);
        y = bound(y + ((vy * dt) >>> 16), y_lo, y_hi);
        rad = yaw * dt;
        mag = (rad < 0) ? longint'(-rad) : longint'(rad);
        q = (mag >> 32) * OneTurnInv + (((mag & 64'hFFFFFFFF) * OneTurnInv) >> 32);
        if (rad < 0) q = 64'd0 - q;
        h = h + q[31:0];
    endfunction

    function automatic t_pose predict_pose(input logic [31:0] sx, input logic [31:0] sy,
                                           input logic [31:0] sh, input logic [31:0] sp,
                                           input logic [30:0] st, input logic [22:0] du);
        longint x;
        longint y;
        longint v;
        longint steer;
        longint sc;
        longint ss;
        longint tn;
        longint yaw;
        longint dt;
        longint wb;
        longint n;
        longint rem;
        logic [31:0] h;
        t_pose r;
        x = longint'(signed'(sx));
        y = longint'(signed'(sy));
        h = sh;
        v = longint'(signed'(sp));
        steer = longint'(signed'(st));
        dt = (dt_reg == 0) ? 1 : dt_reg;
        wb = (wb_reg == 0) ? 1 : wb_reg;
        rotate_q30(steer[31:0], sc, ss);
        if (sc < 1) sc = 1;
        tn = sat_q16((ss * 65536) / sc);
        yaw = sat_q16((v * tn) / wb);
        n = longint'(du) / dt;
        rem = longint'(du) - n * dt;
        for (longint k = 0; k < n; k++) euler_move(x, y, h, v, yaw, dt);
        if (rem != 0) euler_move(x, y, h, v, yaw, rem);
        r.x = x[31:0];
        r.y = y[31:0];
        r.h = h;
        return r;
    endfunction

    // Result checker, receiver stall pattern and the long hold-off.
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result x=%h y=%h h=%h",
                                 o_end_x, o_end_y, o_end_heading);
                end else begin
                    e = pose_q.pop_front();
                    if (e.x !== o_end_x || e.y !== o_end_y || e.h !== o_end_heading) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                                     e.x, e.y, e.h, o_end_x, o_end_y, o_end_heading);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt <= HoldCycles;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SettleGap) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            cpep_pkg::REG_WHEELBASE: wb_reg = longint'(data[30:0]);
            cpep_pkg::REG_TIME_STEP: dt_reg = longint'(data[15:0]);
            cpep_pkg::REG_X_MIN:     x_lo = longint'(signed'(data));
            cpep_pkg::REG_X_MAX:     x_hi = longint'(signed'(data));
            cpep_pkg::REG_Y_MIN:     y_lo = longint'(signed'(data));
            cpep_pkg::REG_Y_MAX:     y_hi = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] wb, input logic [31:0] dt,
                              input logic [31:0] xl, input logic [31:0] xh,
                              input logic [31:0] yl, input logic [31:0] yh);
        wait_idle();
        write_reg(cpep_pkg::REG_WHEELBASE, wb);
        write_reg(cpep_pkg::REG_TIME_STEP, dt);
        write_reg(cpep_pkg::REG_X_MIN, xl);
        write_reg(cpep_pkg::REG_X_MAX, xh);
        write_reg(cpep_pkg::REG_Y_MIN, yl);
        write_reg(cpep_pkg::REG_Y_MAX, yh);
    endtask

    task automatic send_pose(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sh, input logic [31:0] sp,
                             input logic [30:0] st, input logic [22:0] du);
        while (!calm && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_start_heading <= sh;
        i_speed <= sp;
        i_steer_angle <= st;
        i_duration <= du;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pose_q.push_back(predict_pose(sx, sy, sh, sp, st, du));
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Durations stay at a modest number of steps so that the run stays short.
    function automatic logic [22:0] pick_duration(input int max_steps);
        longint dt;
        longint d;
        dt = (dt_reg == 0) ? 1 : dt_reg;
        d = longint'($urandom_range(0, max_steps)) * dt;
        if ($urandom_range(0, 3) != 0) d = d + longint'($urandom_range(0, dt - 1));
        if (d > 4194304) d = 4194304;
        return d[22:0];
    endfunction

    task automatic send_random(input int max_steps);
        send_pose($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                  pick_duration(max_steps));
    endtask

    task automatic test_directed();
        calm = 1'b1;
        send_pose(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h0002_0000, 31'd0, 23'd0);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  31'h3FFF_FFFF, 23'd3291);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                  31'h4000_0001, 23'd2620);
        send_pose(32'd0, 32'd0, 32'h4000_0000, 32'h0005_0000, 31'h4000_0000, 23'd1965);
        send_pose(32'd0, 32'd0, 32'hC000_0000, 32'h0005_0000, 31'h7FFF_FFFF, 23'd1000);
        send_pose(32'd0, 32'd0, 32'h4000_0001, 32'hFFFB_0000, 31'h1000_0000, 23'd1400);
        send_pose(32'h1234_5678, 32'h8765_4321, 32'hBFFF_FFFF, 32'd0, 31'h2000_0000, 23'd700);
        send_pose(32'd0, 32'd0, 32'h2000_0000, 32'h000A_0000, 31'h5000_0000, 23'd655);
        send_pose(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                  31'h0000_0001, 23'd1);
        release_input();
        set_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_pose(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 31'h3FFF_FFFF, 23'h40_0000);
        send_pose(32'd0, 32'd0, 32'd0, 32'h8000_0000, 31'h4000_0001, 23'h3F_FFFF);
        release_input();
        calm = 1'b0;
    endtask

    task automatic test_settings();
        set_config(32'd1, 32'd1, 32'd0, 32'd0, 32'hFFFF_0000, 32'h0001_0000);
        repeat (6) send_random(40);
        release_input();
        set_config(32'd0, 32'd0, 32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        repeat (6) send_random(40);
        release_input();
        set_config(32'h0002_8000, 32'd4096, 32'hFF00_0000, 32'h0100_0000,
                   32'hFF00_0000, 32'h0100_0000);
        repeat (6) send_random(30);
        release_input();
    endtask

    task automatic test_random();
        for (int i = 0; i < 105; i++) begin
            if (i % 35 == 0) begin
                release_input();
                set_config($urandom, $urandom_range(1, 65535),
                           32'h8000_0000 | $urandom_range(0, 32'h00FF_FFFF),
                           $urandom_range(0, 32'h00FF_FFFF),
                           32'h8000_0000 | $urandom_range(0, 32'h00FF_FFFF),
                           $urandom_range(0, 32'h00FF_FFFF));
            end
            calm = (i >= 70 && i < 100);
            send_random(20);
        end
        calm = 1'b0;
        release_input();
    endtask

    task automatic test_backpressure();
        set_config(32'd13107, 32'd655, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        hold_req = 1'b1;
        calm = 1'b1;
        repeat (6) send_random(4);
        calm = 1'b0;
        release_input();
    endtask

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        wb_reg = 13107;
        dt_reg = 655;
        x_lo = -64'sd2147483648;
        x_hi = 64'sd2147483647;
        y_lo = -64'sd2147483648;
        y_hi = 64'sd2147483647;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_start_heading = '0;
        i_speed = '0;
        i_steer_angle = '0;
        i_duration = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatches == 0 && pose_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpep_pkg.sv
rtl/car_pose_euler_propagator.sv
tb/car_pose_euler_propagator_tb.sv
